FILE: sv/ptt_pkg.sv
// Package for the page translation block: sizes, operation and status codes,
// transfer structs and memory write requests. No dependencies.
`default_nettype none

package ptt_pkg;

    localparam int PAGE_SHIFT      = 12;
    localparam int TABLE_BITS      = 10;
    localparam int DIR_BITS        = 4;
    localparam int PPN_BITS        = 14;
    localparam int TLB_INDEX_BITS  = 6;
    localparam int VPN_BITS        = DIR_BITS + TABLE_BITS;
    localparam int VA_W            = 26;
    localparam int PA_W            = 26;
    localparam int CNT_W           = 32;
    localparam int PAGE_ENTRY_BITS = PPN_BITS + 1;
    localparam int TLB_DATA_BITS   = VPN_BITS + PPN_BITS;
    localparam int DIR_COUNT       = 1 << DIR_BITS;
    localparam int TLB_COUNT       = 1 << TLB_INDEX_BITS;

    typedef enum logic [1:0] {
        FUNC_TRANSLATE = 2'd0,
        FUNC_MAP       = 2'd1,
        FUNC_UNMAP     = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FAULT       = 2'd1,
        ST_DOUBLE_FREE = 2'd2
    } status_t;

    typedef struct packed {
        func_t                func;
        logic [VA_W-1:0]      virtual_address;
        logic [PPN_BITS-1:0]  physical_page;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [PA_W-1:0]      physical_address;
        logic                 tlb_hit;
        logic [CNT_W-1:0]     lookup_total;
        logic [CNT_W-1:0]     miss_total;
        logic [CNT_W-1:0]     hit_total;
    } rsp_t;

    typedef struct packed {
        logic                       en;
        logic [VPN_BITS-1:0]        addr;
        logic [PAGE_ENTRY_BITS-1:0] data;
    } pg_wr_t;

    typedef struct packed {
        logic                      en;
        logic [TLB_INDEX_BITS-1:0] addr;
        logic [TLB_DATA_BITS-1:0]  data;
    } tlb_wr_t;

endpackage

`default_nettype wire

FILE: sv/page_translation_with_tlb.sv
// Flow: a request transfer registers the item and the page-table and TLB reads;
// the result is registered into the output register on commit, which waits
// while a stalled result is held. One item is held at a time: req_stall stays
// high from the request transfer until its commit (read, then write-back).
// Reset: directory, TLB valid bits and counters clear at once; then a clearing
// pass writes all 16384 page-table entries, one a cycle, with req_stall high.
// Top level: handshake, clearing pass, output register. Depends on ptt_pkg,
// ptt_ram and ptt_exec.
`default_nettype none

module page_translation_with_tlb
    import ptt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    req_t                rsp_unused_guard;
    req_t                item_reg;
    logic                busy_reg, busy_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg;
    logic                clr_active_reg;
    logic [VPN_BITS-1:0] clr_idx_reg;

    logic                       accept;
    logic                       commit;
    logic [VPN_BITS-1:0]        req_vpn;
    logic [PAGE_ENTRY_BITS-1:0] pg_rd;
    logic [TLB_DATA_BITS-1:0]   tlb_rd;
    pg_wr_t                     exec_pg_wr;
    pg_wr_t                     pg_wr;
    tlb_wr_t                    exec_tlb_wr;
    rsp_t                       exec_rsp;

    assign rsp_unused_guard = item_reg;
    assign req_stall = clr_active_reg || busy_reg;
    assign accept    = req_valid && !req_stall;
    assign commit    = busy_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_vpn   = req.virtual_address[PAGE_SHIFT +: VPN_BITS];

    always_comb
    begin
        if (clr_active_reg)
        begin
            pg_wr = '{en: 1'b1, addr: clr_idx_reg, data: '0};
        end
        else
        begin
            pg_wr = exec_pg_wr;
        end
        busy_next      = accept ? 1'b1 : (commit ? 1'b0 : busy_reg);
        rsp_valid_next = commit ? 1'b1 : (rsp_valid_reg && rsp_stall);
    end

    ptt_ram #(
        .WIDTH     (PAGE_ENTRY_BITS),
        .ADDR_BITS (VPN_BITS)
    ) u_page_ram (
        .clk     (clk),
        .wr_en   (pg_wr.en),
        .wr_addr (pg_wr.addr),
        .wr_data (pg_wr.data),
        .rd_en   (accept),
        .rd_addr (req_vpn),
        .rd_data (pg_rd)
    );

    ptt_ram #(
        .WIDTH     (TLB_DATA_BITS),
        .ADDR_BITS (TLB_INDEX_BITS)
    ) u_tlb_ram (
        .clk     (clk),
        .wr_en   (exec_tlb_wr.en),
        .wr_addr (exec_tlb_wr.addr),
        .wr_data (exec_tlb_wr.data),
        .rd_en   (accept),
        .rd_addr (req_vpn[TLB_INDEX_BITS-1:0]),
        .rd_data (tlb_rd)
    );

    ptt_exec u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .item   (rsp_unused_guard),
        .pg_rd  (pg_rd),
        .tlb_rd (tlb_rd),
        .pg_wr  (exec_pg_wr),
        .tlb_wr (exec_tlb_wr),
        .rsp    (exec_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
            if (clr_active_reg)
            begin
                clr_idx_reg <= clr_idx_reg + VPN_BITS'(1);
                if (clr_idx_reg == {VPN_BITS{1'b1}})
                begin
                    clr_active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        if (commit)
        begin
            rsp_reg <= exec_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && !accept)
        else $error("request transfer while an item is held");

    a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !busy_reg && !rsp_valid_reg && !exec_tlb_wr.en)
        else $error("activity during page-table clearing pass");

    a_commit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp_valid_reg && (rsp_reg == $past(exec_rsp)))
        else $error("committed result not presented");

    a_fault_zero_address: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status != ST_OK)
            |-> (rsp_reg.physical_address == '0) && !rsp_reg.tlb_hit)
        else $error("failed operation carries an address or hit flag");
`endif

endmodule

`default_nettype wire

FILE: sv/ptt_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered when rd_en is high. No dependencies.
`default_nettype none

module ptt_ram #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 4
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/ptt_exec.sv
// Execute stage: decodes the held item against page-table and TLB read data,
// builds the result and memory write-backs, and owns counters, directory and
// TLB valid bits. Depends on ptt_pkg.
`default_nettype none

module ptt_exec
    import ptt_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       commit,
    input  wire req_t                       item,
    input  wire logic [PAGE_ENTRY_BITS-1:0] pg_rd,
    input  wire logic [TLB_DATA_BITS-1:0]   tlb_rd,
    output pg_wr_t                          pg_wr,
    output tlb_wr_t                         tlb_wr,
    output rsp_t                            rsp
);

    logic [CNT_W-1:0]     lookups_reg, lookups_next;
    logic [CNT_W-1:0]     misses_reg, misses_next;
    logic [CNT_W-1:0]     hits_reg, hits_next;
    logic [DIR_COUNT-1:0] dir_valid_reg;
    logic [TLB_COUNT-1:0] tlb_valid_reg;

    logic [VPN_BITS-1:0]       vpn;
    logic [PAGE_SHIFT-1:0]     offset;
    logic [TLB_INDEX_BITS-1:0] tlb_idx;
    logic [DIR_BITS-1:0]       dir_idx;
    logic                      va_zero;
    logic                      ent_valid;
    logic [PPN_BITS-1:0]       ent_ppn;
    logic [VPN_BITS-1:0]       tlb_vpn;
    logic [PPN_BITS-1:0]       tlb_ppn;
    logic                      tlb_match;
    logic                      dir_ok;

    logic do_lookup, do_hit, do_fill, dir_set, tlb_set, tlb_clr;

    assign vpn       = item.virtual_address[PAGE_SHIFT +: VPN_BITS];
    assign offset    = item.virtual_address[PAGE_SHIFT-1:0];
    assign tlb_idx   = vpn[TLB_INDEX_BITS-1:0];
    assign dir_idx   = vpn[VPN_BITS-1 -: DIR_BITS];
    assign va_zero   = (item.virtual_address == '0);
    assign ent_valid = pg_rd[PPN_BITS];
    assign ent_ppn   = pg_rd[PPN_BITS-1:0];
    assign tlb_vpn   = tlb_rd[TLB_DATA_BITS-1 -: VPN_BITS];
    assign tlb_ppn   = tlb_rd[PPN_BITS-1:0];
    assign tlb_match = tlb_valid_reg[tlb_idx] && (tlb_vpn == vpn);
    assign dir_ok    = dir_valid_reg[dir_idx];

    always_comb
    begin
        rsp.status           = ST_FAULT;
        rsp.physical_address = '0;
        rsp.tlb_hit          = 1'b0;
        do_lookup            = 1'b0;
        do_hit               = 1'b0;
        do_fill              = 1'b0;
        dir_set              = 1'b0;
        tlb_set              = 1'b0;
        tlb_clr              = 1'b0;
        pg_wr                = '0;
        tlb_wr               = '0;
        unique case (item.func)
            FUNC_TRANSLATE:
            begin
                if (!va_zero && ent_valid)
                begin
                    do_lookup = 1'b1;
                    if (tlb_match)
                    begin
                        do_hit               = 1'b1;
                        rsp.tlb_hit          = 1'b1;
                        rsp.status           = ST_OK;
                        rsp.physical_address = PA_W'({tlb_ppn, offset});
                    end
                    else if (dir_ok)
                    begin
                        do_fill              = 1'b1;
                        tlb_set              = 1'b1;
                        tlb_wr               = '{en: 1'b1, addr: tlb_idx, data: {vpn, ent_ppn}};
                        rsp.status           = ST_OK;
                        rsp.physical_address = PA_W'({ent_ppn, offset});
                    end
                end
            end
            FUNC_MAP:
            begin
                dir_set    = 1'b1;
                do_lookup  = 1'b1;
                do_fill    = 1'b1;
                tlb_set    = 1'b1;
                pg_wr      = '{en: 1'b1, addr: vpn, data: {1'b1, item.physical_page}};
                tlb_wr     = '{en: 1'b1, addr: tlb_idx, data: {vpn, item.physical_page}};
                rsp.status = ST_OK;
            end
            FUNC_UNMAP:
            begin
                if (!va_zero)
                begin
                    if (!ent_valid)
                    begin
                        rsp.status = ST_DOUBLE_FREE;
                    end
                    else
                    begin
                        rsp.status = ST_OK;
                        do_lookup  = 1'b1;
                        if (tlb_match)
                        begin
                            do_hit               = 1'b1;
                            rsp.physical_address = PA_W'({tlb_ppn, {PAGE_SHIFT{1'b0}}});
                        end
                        else if (dir_ok)
                        begin
                            do_fill              = 1'b1;
                            rsp.physical_address = PA_W'({ent_ppn, {PAGE_SHIFT{1'b0}}});
                        end
                        tlb_clr = tlb_match || dir_ok;
                        pg_wr   = '{en: 1'b1, addr: vpn, data: '0};
                    end
                end
            end
            default:
            begin
                rsp.status = ST_FAULT;
            end
        endcase
        lookups_next     = lookups_reg + CNT_W'(do_lookup);
        misses_next      = misses_reg + CNT_W'(do_fill);
        hits_next        = hits_reg + CNT_W'(do_hit);
        rsp.lookup_total = lookups_next;
        rsp.miss_total   = misses_next;
        rsp.hit_total    = hits_next;
        pg_wr.en         = pg_wr.en && commit;
        tlb_wr.en        = tlb_wr.en && commit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookups_reg   <= '0;
            misses_reg    <= '0;
            hits_reg      <= '0;
            dir_valid_reg <= '0;
            tlb_valid_reg <= '0;
        end
        else if (commit)
        begin
            lookups_reg <= lookups_next;
            misses_reg  <= misses_next;
            hits_reg    <= hits_next;
            if (dir_set)
            begin
                dir_valid_reg[dir_idx] <= 1'b1;
            end
            if (tlb_set)
            begin
                tlb_valid_reg[tlb_idx] <= 1'b1;
            end
            else if (tlb_clr)
            begin
                tlb_valid_reg[tlb_idx] <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Testbench for page_translation_with_tlb: directed and random translate, map and unmap
// transfers checked field by field against an in-bench page table and TLB predictor.
// Depends on ptt_pkg and the page_translation_with_tlb RTL.
`timescale 1ns / 1ps

module tb
    import ptt_pkg::*;
;

    localparam func_t FUNC_UNDEFINED = func_t'(2'd3);
    localparam int    PAGE_COUNT     = 1 << VPN_BITS;
    localparam int    POOL_SIZE      = 32;
    localparam int    RESULT_LATENCY = 2;
    localparam int    LONG_HOLD      = 300;
    localparam int    WATCHDOG_LIMIT = 60000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    bit                dir_valid [DIR_COUNT];
    bit                pte_valid [PAGE_COUNT];
    bit [PPN_BITS-1:0] pte_frame [PAGE_COUNT];
    bit                tlb_valid [TLB_COUNT];
    bit [VPN_BITS-1:0] tlb_vpn   [TLB_COUNT];
    bit [PPN_BITS-1:0] tlb_frame [TLB_COUNT];
    bit [CNT_W-1:0]    lookup_cnt;
    bit [CNT_W-1:0]    miss_cnt;
    bit [CNT_W-1:0]    hit_cnt;

    rsp_t              expected_translations [$];
    bit [VPN_BITS-1:0] vpn_pool [POOL_SIZE];
    int                error_count;
    int                idle_cycles;
    int                stall_mode;
    bit                hold_off_request;

    page_translation_with_tlb dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void fill_tlb(bit [VPN_BITS-1:0] vpn, bit [PPN_BITS-1:0] frame);
        bit [TLB_INDEX_BITS-1:0] slot;
        slot = vpn[TLB_INDEX_BITS-1:0];
        miss_cnt++;
        tlb_valid[slot] = 1'b1;
        tlb_vpn[slot]   = vpn;
        tlb_frame[slot] = frame;
    endfunction

    function automatic bit walk_pages(bit [VPN_BITS-1:0] vpn, output bit [PPN_BITS-1:0] frame,
                                      output bit hit);
        bit [TLB_INDEX_BITS-1:0] slot;
        slot  = vpn[TLB_INDEX_BITS-1:0];
        hit   = 1'b0;
        frame = '0;
        if (!pte_valid[vpn])
            return 1'b0;
        lookup_cnt++;
        if (tlb_valid[slot] && tlb_vpn[slot] == vpn)
        begin
            hit_cnt++;
            hit   = 1'b1;
            frame = tlb_frame[slot];
            return 1'b1;
        end
        if (!dir_valid[vpn[VPN_BITS-1:TABLE_BITS]])
            return 1'b0;
        frame = pte_frame[vpn];
        fill_tlb(vpn, frame);
        return 1'b1;
    endfunction

    function automatic rsp_t predict_translation(req_t r);
        rsp_t                    res;
        bit [VPN_BITS-1:0]       vpn;
        bit [PAGE_SHIFT-1:0]     off;
        bit [PPN_BITS-1:0]       frame;
        bit                      hit;
        bit [TLB_INDEX_BITS-1:0] slot;
        vpn  = r.virtual_address[VA_W-1:PAGE_SHIFT];
        off  = r.virtual_address[PAGE_SHIFT-1:0];
        slot = vpn[TLB_INDEX_BITS-1:0];
        res  = '0;
        res.status = ST_FAULT;
        case (r.func)
            FUNC_TRANSLATE:
            begin
                if (r.virtual_address != '0)
                begin
                    if (walk_pages(vpn, frame, hit))
                    begin
                        res.status           = ST_OK;
                        res.physical_address = {frame, off};
                    end
                    res.tlb_hit = hit;
                end
            end
            FUNC_MAP:
            begin
                dir_valid[vpn[VPN_BITS-1:TABLE_BITS]] = 1'b1;
                pte_valid[vpn] = 1'b1;
                pte_frame[vpn] = r.physical_page;
                fill_tlb(vpn, r.physical_page);
                lookup_cnt++;
                res.status = ST_OK;
            end
            FUNC_UNMAP:
            begin
                if (r.virtual_address != '0)
                begin
                    if (!pte_valid[vpn])
                        res.status = ST_DOUBLE_FREE;
                    else
                    begin
                        if (walk_pages(vpn, frame, hit))
                            res.physical_address = {frame, {PAGE_SHIFT{1'b0}}};
                        pte_valid[vpn] = 1'b0;
                        if (tlb_valid[slot] && tlb_vpn[slot] == vpn)
                            tlb_valid[slot] = 1'b0;
                        res.status = ST_OK;
                    end
                end
            end
            default:
                res.status = ST_FAULT;
        endcase
        res.lookup_total = lookup_cnt;
        res.miss_total   = miss_cnt;
        res.hit_total    = hit_cnt;
        return res;
    endfunction

    function automatic req_t make_req(func_t f, bit [VPN_BITS-1:0] vpn,
                                      bit [PAGE_SHIFT-1:0] off, bit [PPN_BITS-1:0] page);
        req_t r;
        r.func            = f;
        r.virtual_address = {vpn, off};
        r.physical_page   = page;
        return r;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.func = FUNC_TRANSLATE;
        else if (pick < 80)
            r.func = FUNC_MAP;
        else
            r.func = FUNC_UNMAP;
        if ($urandom_range(0, 9) == 0)
            r.virtual_address = VA_W'($urandom);
        else
            r.virtual_address = {vpn_pool[$urandom_range(0, POOL_SIZE - 1)],
                                 PAGE_SHIFT'($urandom)};
        if ($urandom_range(0, 49) == 0)
            r.virtual_address = '0;
        r.physical_page = PPN_BITS'($urandom);
        return r;
    endfunction

    function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_item(req_t item);
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        expected_translations.push_back(predict_translation(item));
    endtask

    task automatic idle_sender(int cycles);
        if (cycles > 0)
        begin
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (expected_translations.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic send_random_bursts(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                send_item(random_request());
                sent++;
            end
            idle_sender($urandom_range(0, 6));
        end
    endtask

    task automatic test_directed();
        send_item(make_req(FUNC_TRANSLATE, 14'h0000, 12'h000, 14'h0000));
        send_item(make_req(FUNC_TRANSLATE, 14'h0005, 12'h234, 14'h0000));
        send_item(make_req(FUNC_UNMAP,     14'h0000, 12'h000, 14'h0000));
        send_item(make_req(FUNC_UNMAP,     14'h0005, 12'h000, 14'h0000));
        send_item(make_req(FUNC_MAP,       14'h0000, 12'h000, 14'h3FFF));
        send_item(make_req(FUNC_TRANSLATE, 14'h0000, 12'h000, 14'h0000));
        send_item(make_req(FUNC_TRANSLATE, 14'h0000, 12'hFFF, 14'h0000));
        send_item(make_req(FUNC_MAP,       14'h3FFF, 12'hFFF, 14'h0000));
        send_item(make_req(FUNC_TRANSLATE, 14'h3FFF, 12'hFFF, 14'h3FFF));
        send_item(make_req(FUNC_MAP,       14'h3FBF, 12'h000, 14'h2AAA));
        send_item(make_req(FUNC_TRANSLATE, 14'h3FFF, 12'h000, 14'h0000));
        send_item(make_req(FUNC_TRANSLATE, 14'h3FBF, 12'h800, 14'h0000));
        send_item(make_req(FUNC_MAP,       14'h3FFF, 12'h5A5, 14'h1555));
        send_item(make_req(FUNC_TRANSLATE, 14'h3FFF, 12'h123, 14'h0000));
        send_item(make_req(FUNC_UNMAP,     14'h3FFF, 12'h456, 14'h0000));
        send_item(make_req(FUNC_UNMAP,     14'h3FFF, 12'h000, 14'h0000));
        send_item(make_req(FUNC_TRANSLATE, 14'h3FFF, 12'h000, 14'h0000));
        send_item(make_req(FUNC_MAP,       14'h013F, 12'h001, 14'h0001));
        send_item(make_req(FUNC_UNMAP,     14'h3FBF, 12'h000, 14'h0000));
        send_item(make_req(FUNC_TRANSLATE, 14'h3FBF, 12'h000, 14'h0000));
        send_item(make_req(FUNC_UNMAP,     14'h0000, 12'h001, 14'h0000));
        send_item(make_req(FUNC_UNDEFINED, 14'h1234, 12'h567, 14'h3FFF));
        send_item(make_req(FUNC_TRANSLATE, 14'h013F, 12'hABC, 14'h0000));
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        send_random_bursts(400);
    endtask

    task automatic test_backpressure();
        hold_off_request = 1'b1;
        repeat (40) send_item(random_request());
    endtask

    task automatic test_drain_pause();
        send_random_bursts(20);
        wait_for_results();
        send_random_bursts(20);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                stall_mode = $urandom_range(0, 2);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else if (stall_mode == 1)
                rsp_stall <= ($urandom_range(0, 99) < 30);
            else if (stall_mode == 2)
                rsp_stall <= ($urandom_range(0, 99) < 75);
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_translations.size() == 0)
            begin
                $error("result transfer with no pending expectation");
                error_count++;
            end
            else
            begin
                rsp_t want;
                want = expected_translations.pop_front();
                check_field("status",           CNT_W'(want.status),           CNT_W'(rsp.status));
                check_field("physical_address", CNT_W'(want.physical_address),
                            CNT_W'(rsp.physical_address));
                check_field("tlb_hit",          CNT_W'(want.tlb_hit),          CNT_W'(rsp.tlb_hit));
                check_field("lookup_total",     want.lookup_total,             rsp.lookup_total);
                check_field("miss_total",       want.miss_total,               rsp.miss_total);
                check_field("hit_total",        want.hit_total,                rsp.hit_total);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i += 2)
        begin
            vpn_pool[i]     = VPN_BITS'($urandom);
            vpn_pool[i + 1] = vpn_pool[i] ^
                              {(VPN_BITS - TLB_INDEX_BITS)'($urandom_range(1, 255)),
                               {TLB_INDEX_BITS{1'b0}}};
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic();
        test_backpressure();
        test_drain_pause();
        wait_for_results();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
